FILE: src/rtdi_pkg.sv
package rtdi_pkg;

    // Fixed field widths of the command and result beats.
    localparam int INDEX_W  = 5;
    localparam int IN_ROW_W = 8;
    localparam int DIST_W   = 15;
    localparam int OUT_W    = 24;

    // Saturation limits of the signed result.
    localparam int OUT_MAX = 8388607;
    localparam int OUT_MIN = -8388608;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [INDEX_W-1:0]  entry_index;
        logic [IN_ROW_W-1:0] entry_row;
        logic [DIST_W-1:0]   entry_dist;
        logic [IN_ROW_W-1:0] query_row;
    } item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] distance_q8;
        logic                    found;
        logic                    div_error;
    } result_t;

endpackage

FILE: src/row_to_distance_interpolator_top.sv
// Load beats in range write one breakpoint in the accept cycle and never raise busy.
// A query scans one segment per cycle, multiplies once, then divides one quotient bit per
// cycle. done comes straight from the scan on a miss or a zero denominator, from the sum
// step with no division when the first segment's rows fall, else from the sum step after
// the division. The next beat is taken while done is shown, so a query holds off new beats
// until it is through; the receiver cannot stall. Reset clears sequencer and outputs.
module row_to_distance_interpolator_top #(
    parameter int NUM_POINTS = 18,
    parameter int ROW_BITS   = 8,
    parameter int FRAC_BITS  = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  rtdi_pkg::item_t req,
    output logic            done,
    output rtdi_pkg::result_t result
);
    import rtdi_pkg::*;

    localparam int IDX_W = $clog2(NUM_POINTS);
    localparam int MAG_W = ROW_BITS + DIST_W;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int EXT_W = (NUM_W + 2 > OUT_W) ? NUM_W + 2 : OUT_W;
    localparam logic [IDX_W-1:0] LAST_K = IDX_W'(NUM_POINTS - 1);
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(OUT_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(OUT_MIN);

    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [DIST_W-1:0]   distance;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_SUM
    } state_t;

    entry_t mem [NUM_POINTS];

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    result_t             result_reg, result_next;
    logic [ROW_BITS-1:0] q_reg, q_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    entry_t              rd_reg;
    entry_t              prev_reg, prev_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [ROW_BITS-1:0] den_reg, den_next;
    logic [ROW_BITS-1:0] rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                accept;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;

    logic signed [ROW_BITS:0] off;
    logic signed [DIST_W:0]   dd;
    logic [ROW_BITS-1:0]      off_mag;
    logic [DIST_W-1:0]        dd_mag;
    logic [MAG_W-1:0]         mag;
    logic [ROW_BITS:0]        shifted;
    logic                     ge;
    logic [EXT_W-1:0]         base;
    logic [EXT_W-1:0]         quo;
    logic signed [EXT_W-1:0]  sum;

    assign accept  = start && !busy;
    assign wr_en   = accept && (req.cmd == CMD_LOAD) && (req.entry_index < NUM_POINTS);
    assign wr_addr = IDX_W'(req.entry_index);

    // Datapath pieces used by the sequencer.
    always_comb
    begin
        off     = $signed({1'b0, q_reg}) - $signed({1'b0, prev_reg.row});
        dd      = $signed({1'b0, rd_reg.distance}) - $signed({1'b0, prev_reg.distance});
        off_mag = off[ROW_BITS] ? ROW_BITS'(-off) : off[ROW_BITS-1:0];
        dd_mag  = dd[DIST_W] ? DIST_W'(-dd) : dd[DIST_W-1:0];
        mag     = MAG_W'(off_mag) * MAG_W'(dd_mag);
        shifted = {rem_reg, num_reg[NUM_W-1]};
        ge      = shifted >= {1'b0, den_reg};
        base    = EXT_W'(prev_reg.distance) << FRAC_BITS;
        quo     = neg_reg ? -EXT_W'(num_reg) : EXT_W'(num_reg);
        sum     = $signed(base) + $signed(quo);
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        q_next      = q_reg;
        k_next      = k_reg;
        prev_next   = prev_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        rd_en       = 1'b0;
        rd_addr     = k_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.cmd == CMD_QUERY)
                begin
                    q_next     = ROW_BITS'(req.query_row);
                    k_next     = IDX_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                prev_next  = rd_reg;
                rd_en      = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // rd_reg holds entry k, prev_reg holds entry k-1.
                if (q_reg < rd_reg.row)
                begin
                    if (rd_reg.row == prev_reg.row)
                    begin
                        result_next.distance_q8 = '0;
                        result_next.found       = 1'b1;
                        result_next.div_error   = 1'b1;
                        done_next               = 1'b1;
                        state_next              = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
                else if (k_reg == LAST_K)
                begin
                    result_next.distance_q8 = '0;
                    result_next.found       = 1'b0;
                    result_next.div_error   = 1'b0;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    prev_next = rd_reg;
                    rd_en     = 1'b1;
                    rd_addr   = k_reg + IDX_W'(1);
                    k_next    = k_reg + IDX_W'(1);
                end
            end
            ST_MUL:
            begin
                neg_next = off[ROW_BITS] != dd[DIST_W];
                den_next = rd_reg.row - prev_reg.row;
                rem_next = '0;
                cnt_next = CNT_W'(NUM_W - 1);
                // A first segment whose rows fall gives a zero quotient.
                if (rd_reg.row < prev_reg.row)
                begin
                    num_next   = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    num_next   = NUM_W'(mag) << FRAC_BITS;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? ROW_BITS'(shifted - {1'b0, den_reg}) : ROW_BITS'(shifted);
                num_next = {num_reg[NUM_W-2:0], ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sum > SAT_HI)
                begin
                    result_next.distance_q8 = OUT_W'(SAT_HI);
                end
                else if (sum < SAT_LO)
                begin
                    result_next.distance_q8 = OUT_W'(SAT_LO);
                end
                else
                begin
                    result_next.distance_q8 = OUT_W'(sum);
                end
                result_next.found     = 1'b1;
                result_next.div_error = 1'b0;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= q_next;
        k_reg    <= k_next;
        prev_reg <= prev_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= '{row: ROW_BITS'(req.entry_row), distance: req.entry_dist};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // A result beat is only shown once the sequencer is back at rest.
    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // A load beat never produces a result and never occupies the block.
    a_load_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_LOAD) |=> (!busy && !done))
        else $error("load beat disturbed the sequencer");

    // A query beat always starts a scan.
    a_query_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req.cmd == CMD_QUERY) |=> busy)
        else $error("query beat not taken");

    // Miss and zero-denominator results carry a zero distance.
    a_flags : assert property (@(posedge clk) disable iff (!rst_n)
        (done && (!result.found || result.div_error)) |->
            (result.distance_q8 == '0 && (result.found || !result.div_error)))
        else $error("inconsistent result flags");

endmodule
